/* design/avr_program_flow_unit_assert.svh */
// Assertion macros used by the checker file of the program-flow unit.
`ifndef AVR_PROGRAM_FLOW_UNIT_ASSERT_SVH
`define AVR_PROGRAM_FLOW_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define AVRPF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("program-flow unit assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AVRPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("program-flow unit assertion failed");

// Next-cycle implication that is also checked across reset.
`define AVRPF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("program-flow unit assertion failed");

`endif

/* design/avrpf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package avrpf_pkg;

   typedef enum logic [4:0] {
      OP_RJMP  = 5'd0,
      OP_IJMP  = 5'd1,
      OP_JMP   = 5'd2,
      OP_RCALL = 5'd3,
      OP_ICALL = 5'd4,
      OP_RET   = 5'd5,
      OP_RETI  = 5'd6,
      OP_CPSE  = 5'd7,
      OP_CP    = 5'd8,
      OP_CPC   = 5'd9,
      OP_CPI   = 5'd10,
      OP_SBRC  = 5'd11,
      OP_SBRS  = 5'd12,
      OP_SBIC  = 5'd13,
      OP_SBIS  = 5'd14,
      OP_BRBS  = 5'd15,
      OP_BRBC  = 5'd16
   } op_type;

   typedef struct packed {
      logic i;
      logic t;
      logic h;
      logic s;
      logic v;
      logic n;
      logic z;
      logic c;
   } sreg_type;

   typedef struct packed {
      op_type      op;
      logic [11:0] offset;
      logic [15:0] target;
      logic [15:0] z_pointer;
      logic [7:0]  rd_value;
      logic [7:0]  rr_value;
      logic [2:0]  bit_index;
      logic [7:0]  io_value;
   } req_type;

endpackage

`default_nettype wire

/* design/avr_program_flow_unit.sv */
// A request finishes in state S_FIRST, a call in S_SECOND and a return in
// S_THIRD; the result then sits in the output register until taken.
// Throughput: one request per cycle for jumps, skips, compares and branches
// while the output is not stalled; calls and returns hold off new requests
// until done, set by the single write port and registered stack memory read.
// Reset: PC and SREG clear, the stack pointer goes to all ones, no memory clear.
`timescale 1ns / 1ps
`default_nettype none

module avr_program_flow_unit #(
   parameter int PC_BITS         = 16,
   parameter int STACK_ADDR_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [4:0]         req_op,
   input  logic signed [11:0] req_offset,
   input  logic [15:0]        req_target,
   input  logic [15:0]        req_z_pointer,
   input  logic [7:0]         req_rd_value,
   input  logic [7:0]         req_rr_value,
   input  logic [2:0]         req_bit_index,
   input  logic [7:0]         req_io_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_next_pc,
   output logic [7:0]         rsp_status_flags,
   output logic [9:0]         rsp_stack_pointer,
   output logic               rsp_taken
);

   import avrpf_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_FIRST, S_SECOND, S_THIRD} state_type;

   localparam logic [STACK_ADDR_BITS-1:0] SP_ONE = 1;

   state_type                  state_ff, state_in;
   logic [PC_BITS-1:0]         pc_ff, pc_in;
   sreg_type                   sreg_ff, sreg_in;
   logic [STACK_ADDR_BITS-1:0] sp_ff, sp_in;
   req_type                    req_ff, req_in;
   logic [7:0]                 hi_ff, hi_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [15:0]                rsp_next_pc_ff, rsp_next_pc_in;
   logic [7:0]                 rsp_status_ff, rsp_status_in;
   logic [9:0]                 rsp_sp_ff, rsp_sp_in;
   logic                       rsp_taken_ff, rsp_taken_in;

   logic [PC_BITS-1:0]         ex_next_pc;
   logic [PC_BITS-1:0]         ex_seq_pc;
   sreg_type                   ex_sreg;
   logic                       ex_taken;

   logic                       mem_we;
   logic [STACK_ADDR_BITS-1:0] mem_waddr;
   logic [7:0]                 mem_wdata;
   logic                       mem_re;
   logic [STACK_ADDR_BITS-1:0] mem_raddr;
   logic [7:0]                 mem_rdata;

   logic                       is_call;
   logic                       is_ret;
   logic                       out_free;
   logic                       last_phase;
   logic                       finish;
   logic                       accept;
   logic [15:0]                ret_addr;
   logic [PC_BITS-1:0]         pc_final;

   avrpf_exec #(
      .PC_BITS (PC_BITS)
   ) u_exec (
      .req      (req_ff),
      .pc       (pc_ff),
      .sreg     (sreg_ff),
      .next_pc  (ex_next_pc),
      .seq_pc   (ex_seq_pc),
      .sreg_out (ex_sreg),
      .taken    (ex_taken)
   );

   avrpf_stack_mem #(
      .ADDR_BITS (STACK_ADDR_BITS)
   ) u_stack_mem (
      .clock      (clock),
      .write_en   (mem_we),
      .write_addr (mem_waddr),
      .write_data (mem_wdata),
      .read_en    (mem_re),
      .read_addr  (mem_raddr),
      .read_data  (mem_rdata)
   );

   always_comb begin
      is_call    = req_ff.op inside {OP_RCALL, OP_ICALL};
      is_ret     = req_ff.op inside {OP_RET, OP_RETI};
      out_free   = !rsp_valid_ff || !rsp_stall;
      last_phase = (state_ff == S_FIRST && !is_call && !is_ret)
                || (state_ff == S_SECOND && is_call)
                || (state_ff == S_THIRD);
      finish     = last_phase && out_free;
      req_stall  = (state_ff != S_IDLE) && !finish;
      accept     = req_valid && !req_stall;
      ret_addr   = 16'(ex_seq_pc);
      pc_final   = is_ret ? PC_BITS'({hi_ff, mem_rdata}) : ex_next_pc;

      state_in       = state_ff;
      pc_in          = pc_ff;
      sreg_in        = sreg_ff;
      sp_in          = sp_ff;
      req_in         = req_ff;
      hi_in          = hi_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_next_pc_in = rsp_next_pc_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_sp_in      = rsp_sp_ff;
      rsp_taken_in   = rsp_taken_ff;
      mem_we         = 1'b0;
      mem_waddr      = sp_ff;
      mem_wdata      = ret_addr[7:0];
      mem_re         = 1'b0;
      mem_raddr      = sp_ff + SP_ONE;

      if (accept) begin
         req_in.op        = op_type'(req_op);
         req_in.offset    = req_offset;
         req_in.target    = req_target;
         req_in.z_pointer = req_z_pointer;
         req_in.rd_value  = req_rd_value;
         req_in.rr_value  = req_rr_value;
         req_in.bit_index = req_bit_index;
         req_in.io_value  = req_io_value;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            if (is_call) begin
               mem_we   = 1'b1;
               sp_in    = sp_ff - SP_ONE;
               state_in = S_SECOND;
            end else if (is_ret) begin
               mem_re   = 1'b1;
               sp_in    = sp_ff + SP_ONE;
               state_in = S_SECOND;
            end
         end
         S_SECOND: begin
            if (is_call) begin
               mem_wdata = ret_addr[15:8];
               if (finish) begin
                  mem_we = 1'b1;
                  sp_in  = sp_ff - SP_ONE;
               end
            end else begin
               mem_re   = 1'b1;
               sp_in    = sp_ff + SP_ONE;
               hi_in    = mem_rdata;
               state_in = S_THIRD;
            end
         end
         S_THIRD: begin
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         state_in       = accept ? S_FIRST : S_IDLE;
         pc_in          = pc_final;
         sreg_in        = ex_sreg;
         rsp_valid_in   = 1'b1;
         rsp_next_pc_in = 16'(pc_final);
         rsp_status_in  = ex_sreg;
         rsp_sp_in      = 10'(sp_in);
         rsp_taken_in   = ex_taken;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      hi_ff          <= hi_in;
      rsp_next_pc_ff <= rsp_next_pc_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_sp_ff      <= rsp_sp_in;
      rsp_taken_ff   <= rsp_taken_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         sreg_ff      <= '0;
         sp_ff        <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         sreg_ff      <= sreg_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_pc       = rsp_next_pc_ff;
   assign rsp_status_flags  = rsp_status_ff;
   assign rsp_stack_pointer = rsp_sp_ff;
   assign rsp_taken         = rsp_taken_ff;

endmodule

`default_nettype wire

/* design/avrpf_stack_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module avrpf_stack_mem #(
   parameter int ADDR_BITS = 10
) (
   input  logic                 clock,
   input  logic                 write_en,
   input  logic [ADDR_BITS-1:0] write_addr,
   input  logic [7:0]           write_data,
   input  logic                 read_en,
   input  logic [ADDR_BITS-1:0] read_addr,
   output logic [7:0]           read_data
);

   logic [7:0] mem_ff [2**ADDR_BITS];
   logic [7:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

/* design/avrpf_exec.sv */
`timescale 1ns / 1ps
`default_nettype none

module avrpf_exec #(
   parameter int PC_BITS = 16
) (
   input  avrpf_pkg::req_type  req,
   input  logic [PC_BITS-1:0]  pc,
   input  avrpf_pkg::sreg_type sreg,
   output logic [PC_BITS-1:0]  next_pc,
   output logic [PC_BITS-1:0]  seq_pc,
   output avrpf_pkg::sreg_type sreg_out,
   output logic                taken
);

   import avrpf_pkg::*;

   localparam logic [PC_BITS-1:0] PC_ONE = 1;
   localparam logic [PC_BITS-1:0] PC_TWO = 2;

   logic signed [11:0] off_s;
   logic [PC_BITS-1:0] off_ext;
   logic [PC_BITS-1:0] rel_pc;
   logic [PC_BITS-1:0] skip_pc;
   logic [7:0]         sreg_bits;
   logic               cin;
   logic [7:0]         diff;
   logic               d3, r3, s3, d7, r7, s7;
   logic               fh, fv, fc, fz;
   sreg_type           cmp_sreg;

   always_comb begin
      off_s     = req.offset;
      off_ext   = PC_BITS'(off_s);
      seq_pc    = pc + PC_ONE;
      rel_pc    = seq_pc + off_ext;
      skip_pc   = pc + PC_TWO;
      sreg_bits = sreg;

      cin  = (req.op == OP_CPC) ? sreg.c : 1'b0;
      diff = req.rd_value - req.rr_value - {7'd0, cin};
      d3   = req.rd_value[3];
      r3   = req.rr_value[3];
      s3   = diff[3];
      d7   = req.rd_value[7];
      r7   = req.rr_value[7];
      s7   = diff[7];
      fh   = (~d3 & r3) | (r3 & s3) | (s3 & ~d3);
      fv   = (d7 & ~r7 & ~s7) | (~d7 & r7 & s7);
      fc   = (~d7 & r7) | (r7 & s7) | (s7 & ~d7);
      fz   = (diff == 8'd0);
      if (req.op == OP_CPC) begin
         fz = fz & sreg.z;
      end
      cmp_sreg   = sreg;
      cmp_sreg.h = fh;
      cmp_sreg.s = s7 ^ fv;
      cmp_sreg.v = fv;
      cmp_sreg.n = s7;
      cmp_sreg.z = fz;
      cmp_sreg.c = fc;

      next_pc  = seq_pc;
      sreg_out = sreg;
      taken    = 1'b0;
      case (req.op)
         OP_RJMP, OP_RCALL: begin
            next_pc = rel_pc;
            taken   = 1'b1;
         end
         OP_IJMP, OP_ICALL: begin
            next_pc = PC_BITS'(req.z_pointer);
            taken   = 1'b1;
         end
         OP_JMP: begin
            next_pc = PC_BITS'(req.target);
            taken   = 1'b1;
         end
         OP_RET: begin
            taken = 1'b1;
         end
         OP_RETI: begin
            taken      = 1'b1;
            sreg_out.i = 1'b1;
         end
         OP_CPSE: begin
            if (req.rd_value == req.rr_value) begin
               next_pc = skip_pc;
               taken   = 1'b1;
            end
         end
         OP_CP, OP_CPC, OP_CPI: begin
            sreg_out = cmp_sreg;
         end
         OP_SBRC: begin
            if (!req.rr_value[req.bit_index]) begin
               next_pc = skip_pc;
               taken   = 1'b1;
            end
         end
         OP_SBRS: begin
            if (req.rr_value[req.bit_index]) begin
               next_pc = skip_pc;
               taken   = 1'b1;
            end
         end
         OP_SBIC: begin
            if (!req.io_value[req.bit_index]) begin
               next_pc = skip_pc;
               taken   = 1'b1;
            end
         end
         OP_SBIS: begin
            if (req.io_value[req.bit_index]) begin
               next_pc = skip_pc;
               taken   = 1'b1;
            end
         end
         OP_BRBS: begin
            if (sreg_bits[req.bit_index]) begin
               next_pc = rel_pc;
               taken   = 1'b1;
            end
         end
         OP_BRBC: begin
            if (!sreg_bits[req.bit_index]) begin
               next_pc = rel_pc;
               taken   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

/* design/avrpf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "avr_program_flow_unit_assert.svh"

module avrpf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall
);

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       req_fire;
   logic       rsp_fire;

   always_comb begin
      req_fire   = req_valid && !req_stall;
      rsp_fire   = rsp_valid && !rsp_stall;
      pending_in = pending_ff + {2'd0, req_fire} - {2'd0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A result always belongs to a request that has been taken in.
   `AVRPF_ASSERT_NOW(a_rsp_has_request, clock, reset, rsp_valid, pending_ff != 3'd0)

   // At most one request in flight plus one waiting result.
   `AVRPF_ASSERT_NOW(a_pending_bound, clock, reset, 1'b1, pending_ff <= 3'd2)

   // The output register is empty right after reset.
   `AVRPF_ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, !rsp_valid)

   // A stalled result stays offered.
   `AVRPF_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind avr_program_flow_unit avrpf_checker u_checker (.*);

`default_nettype wire

/* test/avr_program_flow_unit_test.sv */
`timescale 1ns / 1ps

module avr_program_flow_unit_test;
   import avrpf_pkg::*;

   localparam int STACK_DEPTH = 1024;
   localparam int RANDOM_REQUESTS = 1250;
   localparam int DEEP_CALLS = 520;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [4:0] OP_FIRST_UNUSED = 5'd17;
   localparam logic [4:0] OP_LAST_CODE = 5'd31;

   typedef struct packed {
      logic [4:0]  op;
      logic [11:0] offset;
      logic [15:0] target;
      logic [15:0] z_pointer;
      logic [7:0]  rd;
      logic [7:0]  rr;
      logic [2:0]  bit_index;
      logic [7:0]  io;
   } flow_request;

   typedef struct packed {
      logic [15:0] next_pc;
      logic [7:0]  flags;
      logic [9:0]  sp;
      logic        taken;
   } flow_result;

   class flow_scoreboard;
      logic [15:0] pc;
      sreg_type    sreg;
      logic [9:0]  sp;
      logic [7:0]  stack_mem [STACK_DEPTH];
      bit          written [STACK_DEPTH];
      flow_result  expected_outcomes [$];
      int failures, requests, results, calls, returns, taken_count;

      function new();
         pc = '0;
         sreg = '0;
         sp = '1;
      endfunction

      function bit can_return();
         logic [9:0] first, second;
         first = sp + 10'd1;
         second = sp + 10'd2;
         return written[first] && written[second];
      endfunction

      function void push_byte(logic [7:0] b);
         stack_mem[sp] = b;
         written[sp] = 1'b1;
         sp = sp - 10'd1;
      endfunction

      function logic [7:0] pop_byte();
         sp = sp + 10'd1;
         return stack_mem[sp];
      endfunction

      function void update_compare_flags(logic [7:0] rd, logic [7:0] rr, logic cin,
                                         bit keep_z);
         logic [7:0] res;
         res = rd - rr - {7'd0, cin};
         sreg.h = (~rd[3] & rr[3]) | (rr[3] & res[3]) | (res[3] & ~rd[3]);
         sreg.v = (rd[7] & ~rr[7] & ~res[7]) | (~rd[7] & rr[7] & res[7]);
         sreg.c = (~rd[7] & rr[7]) | (rr[7] & res[7]) | (res[7] & ~rd[7]);
         sreg.n = res[7];
         sreg.s = sreg.n ^ sreg.v;
         sreg.z = (res == 8'd0) && (!keep_z || sreg.z);
      endfunction

      function void note_request(flow_request req);
         logic [15:0] seq, rel, skip, next;
         logic [7:0]  hi, lo, flags;
         logic        taken, skip_hit;
         seq = pc + 16'd1;
         rel = pc + {{4{req.offset[11]}}, req.offset} + 16'd1;
         skip = pc + 16'd2;
         flags = sreg;
         next = seq;
         taken = 1'b0;
         skip_hit = 1'b0;
         case (req.op)
            OP_RJMP: begin
               next = rel;
               taken = 1'b1;
            end
            OP_IJMP: begin
               next = req.z_pointer;
               taken = 1'b1;
            end
            OP_JMP: begin
               next = req.target;
               taken = 1'b1;
            end
            OP_RCALL, OP_ICALL: begin
               push_byte(seq[7:0]);
               push_byte(seq[15:8]);
               next = (req.op == OP_RCALL) ? rel : req.z_pointer;
               taken = 1'b1;
               calls++;
            end
            OP_RET, OP_RETI: begin
               hi = pop_byte();
               lo = pop_byte();
               next = {hi, lo};
               if (req.op == OP_RETI) sreg.i = 1'b1;
               taken = 1'b1;
               returns++;
            end
            OP_CPSE: skip_hit = (req.rd == req.rr);
            OP_SBRC: skip_hit = !req.rr[req.bit_index];
            OP_SBRS: skip_hit = req.rr[req.bit_index];
            OP_SBIC: skip_hit = !req.io[req.bit_index];
            OP_SBIS: skip_hit = req.io[req.bit_index];
            OP_CP, OP_CPI: update_compare_flags(req.rd, req.rr, 1'b0, 1'b0);
            OP_CPC: update_compare_flags(req.rd, req.rr, sreg.c, 1'b1);
            OP_BRBS: if (flags[req.bit_index]) begin
               next = rel;
               taken = 1'b1;
            end
            OP_BRBC: if (!flags[req.bit_index]) begin
               next = rel;
               taken = 1'b1;
            end
            default: ;
         endcase
         if (skip_hit) begin
            next = skip;
            taken = 1'b1;
         end
         pc = next;
         requests++;
         if (taken) taken_count++;
         expected_outcomes.push_back(flow_result'{pc, sreg, sp, taken});
      endfunction

      function void check_result(flow_result got);
         flow_result want;
         results++;
         if (expected_outcomes.size() == 0) begin
            $error("result with no request outstanding: next_pc %h", got.next_pc);
            failures++;
            return;
         end
         want = expected_outcomes.pop_front();
         if (got.next_pc !== want.next_pc) begin
            $error("next_pc: expected %h, got %h", want.next_pc, got.next_pc);
            failures++;
         end
         if (got.flags !== want.flags) begin
            $error("status_flags: expected %h, got %h", want.flags, got.flags);
            failures++;
         end
         if (got.sp !== want.sp) begin
            $error("stack_pointer: expected %h, got %h", want.sp, got.sp);
            failures++;
         end
         if (got.taken !== want.taken) begin
            $error("taken: expected %b, got %b", want.taken, got.taken);
            failures++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [4:0]         req_op = '0;
   logic signed [11:0] req_offset = '0;
   logic [15:0]        req_target = '0;
   logic [15:0]        req_z_pointer = '0;
   logic [7:0]         req_rd_value = '0;
   logic [7:0]         req_rr_value = '0;
   logic [2:0]         req_bit_index = '0;
   logic [7:0]         req_io_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [15:0]        rsp_next_pc;
   logic [7:0]         rsp_status_flags;
   logic [9:0]         rsp_stack_pointer;
   logic               rsp_taken;

   flow_scoreboard flow = new();
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int sent = 0;
   int cycle_count = 0;

   avr_program_flow_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_offset(req_offset),
      .req_target(req_target),
      .req_z_pointer(req_z_pointer),
      .req_rd_value(req_rd_value),
      .req_rr_value(req_rr_value),
      .req_bit_index(req_bit_index),
      .req_io_value(req_io_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_next_pc(rsp_next_pc),
      .rsp_status_flags(rsp_status_flags),
      .rsp_stack_pointer(rsp_stack_pointer),
      .rsp_taken(rsp_taken)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         flow.check_result(flow_result'{rsp_next_pc, rsp_status_flags, rsp_stack_pointer,
                                        rsp_taken});
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 14);
      end
   end

   function automatic flow_request make_request(logic [4:0] op, logic [11:0] offset,
                                                logic [15:0] target, logic [15:0] z_pointer,
                                                logic [7:0] rd, logic [7:0] rr,
                                                logic [2:0] bit_index, logic [7:0] io);
      return flow_request'{op, offset, target, z_pointer, rd, rr, bit_index, io};
   endfunction

   function automatic logic [7:0] pick_operand();
      if ($urandom_range(3) != 0) return 8'($urandom);
      case ($urandom_range(4))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h7F;
         3: return 8'h80;
         default: return 8'hFF;
      endcase
   endfunction

   function automatic flow_request random_request(logic [4:0] op);
      flow_request r;
      int k;
      r = make_request(op, 12'($urandom), 16'($urandom), 16'($urandom), pick_operand(),
                       pick_operand(), 3'($urandom), 8'($urandom));
      if ($urandom_range(99) < 40) begin
         k = int'($urandom_range(127)) - 64;
         r.offset = k[11:0];
      end
      if (op == OP_CPSE && $urandom_range(1) == 0) r.rr = r.rd;
      return r;
   endfunction

   function automatic bit is_stack_op(logic [4:0] op);
      return op == OP_RCALL || op == OP_ICALL || op == OP_RET || op == OP_RETI;
   endfunction

   function automatic logic [4:0] free_op();
      logic [4:0] op;
      if ($urandom_range(99) < 5)
         return 5'($urandom_range(int'(OP_LAST_CODE), int'(OP_FIRST_UNUSED)));
      op = 5'($urandom_range(int'(OP_BRBC)));
      if ((op == OP_RET || op == OP_RETI) && !flow.can_return()) op = OP_ICALL;
      return op;
   endfunction

   function automatic logic [4:0] filler_op();
      logic [4:0] op;
      op = 5'($urandom_range(int'(OP_BRBC)));
      while (is_stack_op(op)) op = 5'($urandom_range(int'(OP_BRBC)));
      return op;
   endfunction

   task automatic idle_cycles(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_request(flow_request r);
      if (!quiet && $urandom_range(99) < 14) idle_cycles($urandom_range(1, 4));
      req_valid <= 1'b1;
      req_op <= r.op;
      req_offset <= r.offset;
      req_target <= r.target;
      req_z_pointer <= r.z_pointer;
      req_rd_value <= r.rd;
      req_rr_value <= r.rr;
      req_bit_index <= r.bit_index;
      req_io_value <= r.io;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      flow.note_request(r);
      sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (flow.expected_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic send_fillers();
      repeat ($urandom_range(2)) send_request(random_request(filler_op()));
   endtask

   task automatic send_nest();
      int depth;
      depth = $urandom_range(1, 6);
      repeat (depth) begin
         send_request(random_request($urandom_range(1) ? OP_RCALL : OP_ICALL));
         send_fillers();
      end
      repeat (depth) begin
         send_fillers();
         send_request(random_request($urandom_range(1) ? OP_RET : OP_RETI));
      end
   endtask

   task automatic run_directed();
      send_request(make_request(OP_RCALL, 12'd5, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 8'h00));
      send_request(make_request(OP_RJMP, 12'h800, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 8'h00));
      send_request(make_request(OP_RJMP, 12'h7FF, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 8'h00));
      send_request(make_request(OP_ICALL, 12'h000, 16'h0000, 16'hFFFF, 8'h00, 8'h00, 3'd0, 8'h00));
      send_request(make_request(OP_JMP, 12'h000, 16'hFFFF, 16'h0000, 8'h00, 8'h00, 3'd0, 8'h00));
      send_request(make_request(OP_IJMP, 12'hFFF, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 8'h00));
      send_request(make_request(OP_RET, 12'h000, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 8'h00));
      send_request(make_request(OP_RETI, 12'h000, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 8'h00));
      send_request(make_request(OP_CP, 12'h000, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 8'h00));
      send_request(make_request(OP_CP, 12'h000, 16'h0000, 16'h0000, 8'h00, 8'h01, 3'd0, 8'h00));
      send_request(make_request(OP_CPC, 12'h000, 16'h0000, 16'h0000, 8'h01, 8'h00, 3'd0, 8'h00));
      send_request(make_request(OP_CP, 12'h000, 16'h0000, 16'h0000, 8'h80, 8'h01, 3'd0, 8'h00));
      send_request(make_request(OP_CPC, 12'h000, 16'h0000, 16'h0000, 8'hFF, 8'hFF, 3'd0, 8'h00));
      send_request(make_request(OP_CPI, 12'h000, 16'h0000, 16'h0000, 8'h7F, 8'h80, 3'd0, 8'h00));
      send_request(make_request(OP_CPSE, 12'h000, 16'h0000, 16'h0000, 8'hAA, 8'hAA, 3'd0, 8'h00));
      send_request(make_request(OP_CPSE, 12'h000, 16'h0000, 16'h0000, 8'hAA, 8'h55, 3'd0, 8'h00));
      send_request(make_request(OP_SBRC, 12'h000, 16'h0000, 16'h0000, 8'h00, 8'h7F, 3'd7, 8'h00));
      send_request(make_request(OP_SBRS, 12'h000, 16'h0000, 16'h0000, 8'h00, 8'h80, 3'd7, 8'h00));
      send_request(make_request(OP_SBIC, 12'h000, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 8'hFE));
      send_request(make_request(OP_SBIS, 12'h000, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 8'h01));
      send_request(make_request(OP_BRBS, 12'h03F, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd7, 8'h00));
      send_request(make_request(OP_BRBC, 12'hFC0, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0, 8'h00));
      send_request(make_request(OP_BRBS, 12'h800, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd2, 8'h00));
      send_request(make_request(OP_LAST_CODE, 12'h000, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0,
                                8'h00));
      send_request(make_request(OP_FIRST_UNUSED, 12'h000, 16'h0000, 16'h0000, 8'h00, 8'h00, 3'd0,
                                8'h00));
   endtask

   initial begin
      int goal;
      bit deep_done, hold_done, pause_done;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      wait_drained();
      goal = sent + RANDOM_REQUESTS;
      deep_done = 1'b0;
      hold_done = 1'b0;
      pause_done = 1'b0;
      while (sent < goal) begin
         quiet = (goal - sent) < 350 && (goal - sent) > 250;
         if (!hold_done && goal - sent < 1050) begin
            hold_request = 1'b1;
            repeat (40) send_request(random_request(free_op()));
            hold_done = 1'b1;
         end else if (!deep_done && goal - sent < 850) begin
            repeat (DEEP_CALLS)
               send_request(random_request($urandom_range(1) ? OP_RCALL : OP_ICALL));
            deep_done = 1'b1;
         end else if (!pause_done && goal - sent < 200) begin
            wait_drained();
            pause_done = 1'b1;
         end else if ($urandom_range(99) < 60) begin
            send_nest();
         end else begin
            repeat ($urandom_range(1, 8)) send_request(random_request(free_op()));
         end
      end
      quiet = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests and checked %0d results, %0d of them taken.",
               flow.requests, flow.results, flow.taken_count);
      $display("Stack traffic: %0d calls and %0d returns, including a full wrap of the stack.",
               flow.calls, flow.returns);
      if (flow.failures == 0 && flow.expected_outcomes.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
